/* sv/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge, held off while reset is asserted.
`define CRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, during reset too.
`define CRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRF_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/crf_pkg.sv */
package crf_pkg;

  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_SETF   = 3'd2,
    OP_TEST   = 3'd3,
    OP_PUSH8  = 3'd4,
    OP_PUSH16 = 3'd5,
    OP_POP8   = 3'd6,
    OP_POP16  = 3'd7
  } op_e;

  // Register selectors
  localparam logic [3:0] SEL_A  = 4'd0;
  localparam logic [3:0] SEL_F  = 4'd1;
  localparam logic [3:0] SEL_AF = 4'd2;
  localparam logic [3:0] SEL_B  = 4'd3;
  localparam logic [3:0] SEL_C  = 4'd4;
  localparam logic [3:0] SEL_BC = 4'd5;
  localparam logic [3:0] SEL_D  = 4'd6;
  localparam logic [3:0] SEL_E  = 4'd7;
  localparam logic [3:0] SEL_DE = 4'd8;
  localparam logic [3:0] SEL_H  = 4'd9;
  localparam logic [3:0] SEL_L  = 4'd10;
  localparam logic [3:0] SEL_HL = 4'd11;
  localparam logic [3:0] SEL_SP = 4'd12;
  localparam logic [3:0] SEL_PC = 4'd13;

  // Condition codes
  localparam logic [2:0] CND_NONE = 3'd0;
  localparam logic [2:0] CND_Z    = 3'd1;
  localparam logic [2:0] CND_NZ   = 3'd2;
  localparam logic [2:0] CND_C    = 3'd3;
  localparam logic [2:0] CND_NC   = 3'd4;

  // Byte register slots
  localparam logic [2:0] IX_A = 3'd0;
  localparam logic [2:0] IX_F = 3'd1;
  localparam logic [2:0] IX_B = 3'd2;
  localparam logic [2:0] IX_C = 3'd3;
  localparam logic [2:0] IX_D = 3'd4;
  localparam logic [2:0] IX_E = 3'd5;
  localparam logic [2:0] IX_H = 3'd6;
  localparam logic [2:0] IX_L = 3'd7;

  localparam int unsigned NUM_BYTE_REGS = 8;

  // F bit positions
  localparam logic [2:0] FLAG_Z_BIT = 3'd7;
  localparam logic [2:0] FLAG_N_BIT = 3'd6;
  localparam logic [2:0] FLAG_H_BIT = 3'd5;
  localparam logic [2:0] FLAG_C_BIT = 3'd4;

  typedef struct packed {
    op_e         opcode;
    logic [3:0]  reg_sel;
    logic [15:0] wdata;
    logic [1:0]  flag_z;
    logic [1:0]  flag_n;
    logic [1:0]  flag_h;
    logic [1:0]  flag_c;
    logic [2:0]  cond;
    logic [15:0] stack_bytes;
  } req_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        cond_true;
    logic        bus_valid;
    logic        bus_write;
    logic [15:0] bus_addr;
    logic [7:0]  bus_byte;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic load;  // take the input item and register its first result
    logic step;  // register the second result of a two-byte stack operation
  } cmd_t;

  typedef struct packed {
    logic two_beat;  // input item yields two results
  } sts_t;

endpackage

/* sv/crf_if.sv */
interface crf_req_if;
  import crf_pkg::*;

  logic          valid;
  logic          ready;
  crf_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crf_rsp_if;
  import crf_pkg::*;

  logic          valid;
  logic          ready;
  crf_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/crf_ctrl.sv */
module crf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  crf_pkg::sts_t sts_i,
  output crf_pkg::cmd_t cmd_o
);
  import crf_pkg::*;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_FIRST,
    ST_FINAL
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Take a new item when the output is empty or its final result leaves now.
  assign in_ready_o  = (state_q == ST_EMPTY) || ((state_q == ST_FINAL) && out_ready_i);
  assign out_valid_o = (state_q != ST_EMPTY);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load = accept;
    cmd_o.step = (state_q == ST_FIRST) && out_ready_i;
    state_d    = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (accept) begin
          state_d = sts_i.two_beat ? ST_FIRST : ST_FINAL;
        end
      end
      ST_FIRST: begin
        if (out_ready_i) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (accept) begin
          state_d = sts_i.two_beat ? ST_FIRST : ST_FINAL;
        end else if (out_ready_i) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/crf_dp.sv */
module crf_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  crf_pkg::req_t req_i,
  input  crf_pkg::cmd_t cmd_i,
  output crf_pkg::sts_t sts_o,
  output crf_pkg::rsp_t rsp_o
);
  import crf_pkg::*;

  logic [7:0]  regs_q [NUM_BYTE_REGS];
  logic [7:0]  regs_d [NUM_BYTE_REGS];
  logic [15:0] sp_q, sp_d;
  logic [15:0] pc_q, pc_d;
  logic        pend_push_q;
  logic [15:0] pend_data_q;
  rsp_t        out_q;
  rsp_t        res_first;
  rsp_t        res_second;
  logic [15:0] rd_val;
  logic [15:0] sp_m1;
  logic [15:0] sp_p1;
  logic        flag_z_cur;
  logic        flag_c_cur;
  logic        cond_ok;

  assign sp_m1      = sp_q - 16'd1;
  assign sp_p1      = sp_q + 16'd1;
  assign flag_z_cur = regs_q[IX_F][FLAG_Z_BIT];
  assign flag_c_cur = regs_q[IX_F][FLAG_C_BIT];
  assign sts_o.two_beat = (req_i.opcode == OP_PUSH16) || (req_i.opcode == OP_POP16);
  assign rsp_o = out_q;

  always_comb begin
    unique case (req_i.reg_sel)
      SEL_A:   rd_val = {8'h00, regs_q[IX_A]};
      SEL_F:   rd_val = {8'h00, regs_q[IX_F]};
      SEL_AF:  rd_val = {regs_q[IX_A], regs_q[IX_F]};
      SEL_B:   rd_val = {8'h00, regs_q[IX_B]};
      SEL_C:   rd_val = {8'h00, regs_q[IX_C]};
      SEL_BC:  rd_val = {regs_q[IX_B], regs_q[IX_C]};
      SEL_D:   rd_val = {8'h00, regs_q[IX_D]};
      SEL_E:   rd_val = {8'h00, regs_q[IX_E]};
      SEL_DE:  rd_val = {regs_q[IX_D], regs_q[IX_E]};
      SEL_H:   rd_val = {8'h00, regs_q[IX_H]};
      SEL_L:   rd_val = {8'h00, regs_q[IX_L]};
      SEL_HL:  rd_val = {regs_q[IX_H], regs_q[IX_L]};
      SEL_SP:  rd_val = sp_q;
      SEL_PC:  rd_val = pc_q;
      default: rd_val = 16'h0000;
    endcase
  end

  always_comb begin
    unique case (req_i.cond)
      CND_NONE: cond_ok = 1'b1;
      CND_Z:    cond_ok = flag_z_cur;
      CND_NZ:   cond_ok = !flag_z_cur;
      CND_C:    cond_ok = flag_c_cur;
      CND_NC:   cond_ok = !flag_c_cur;
      default:  cond_ok = 1'b0;
    endcase
  end

  // First result of the incoming item
  always_comb begin
    res_first      = '0;
    res_first.last = 1'b1;
    unique case (req_i.opcode)
      OP_READ:  res_first.rdata = rd_val;
      OP_WRITE: res_first.last  = 1'b1;
      OP_SETF:  res_first.last  = 1'b1;
      OP_TEST:  res_first.cond_true = cond_ok;
      OP_PUSH8: begin
        res_first.bus_valid = 1'b1;
        res_first.bus_write = 1'b1;
        res_first.bus_addr  = sp_m1;
        res_first.bus_byte  = req_i.wdata[7:0];
      end
      OP_PUSH16: begin
        res_first.bus_valid = 1'b1;
        res_first.bus_write = 1'b1;
        res_first.bus_addr  = sp_m1;
        res_first.bus_byte  = req_i.wdata[15:8];
        res_first.last      = 1'b0;
      end
      OP_POP8: begin
        res_first.rdata     = {8'h00, req_i.stack_bytes[7:0]};
        res_first.bus_valid = 1'b1;
        res_first.bus_addr  = sp_q;
      end
      OP_POP16: begin
        res_first.bus_valid = 1'b1;
        res_first.bus_addr  = sp_q;
        res_first.last      = 1'b0;
      end
      default: res_first = '0;
    endcase
  end

  // Second byte access of a 16-bit push or pop
  always_comb begin
    res_second           = '0;
    res_second.bus_valid = 1'b1;
    res_second.last      = 1'b1;
    if (pend_push_q) begin
      res_second.bus_write = 1'b1;
      res_second.bus_addr  = sp_m1;
      res_second.bus_byte  = pend_data_q[7:0];
    end else begin
      res_second.rdata    = pend_data_q;
      res_second.bus_addr = sp_q;
    end
  end

  // Architectural state update
  always_comb begin
    regs_d = regs_q;
    sp_d   = sp_q;
    pc_d   = pc_q;
    if (cmd_i.load) begin
      unique case (req_i.opcode)
        OP_WRITE: begin
          unique case (req_i.reg_sel)
            SEL_A:  regs_d[IX_A] = req_i.wdata[7:0];
            SEL_F:  regs_d[IX_F] = {req_i.wdata[7:4], 4'h0};
            SEL_AF: begin
              regs_d[IX_A] = req_i.wdata[15:8];
              regs_d[IX_F] = {req_i.wdata[7:4], 4'h0};
            end
            SEL_B:  regs_d[IX_B] = req_i.wdata[7:0];
            SEL_C:  regs_d[IX_C] = req_i.wdata[7:0];
            SEL_BC: begin
              regs_d[IX_B] = req_i.wdata[15:8];
              regs_d[IX_C] = req_i.wdata[7:0];
            end
            SEL_D:  regs_d[IX_D] = req_i.wdata[7:0];
            SEL_E:  regs_d[IX_E] = req_i.wdata[7:0];
            SEL_DE: begin
              regs_d[IX_D] = req_i.wdata[15:8];
              regs_d[IX_E] = req_i.wdata[7:0];
            end
            SEL_H:  regs_d[IX_H] = req_i.wdata[7:0];
            SEL_L:  regs_d[IX_L] = req_i.wdata[7:0];
            SEL_HL: begin
              regs_d[IX_H] = req_i.wdata[15:8];
              regs_d[IX_L] = req_i.wdata[7:0];
            end
            SEL_SP:  sp_d = req_i.wdata;
            SEL_PC:  pc_d = req_i.wdata;
            default: sp_d = sp_q;
          endcase
        end
        OP_SETF: begin
          // Codes of two or more keep the flag.
          if (!req_i.flag_z[1]) regs_d[IX_F][FLAG_Z_BIT] = req_i.flag_z[0];
          if (!req_i.flag_n[1]) regs_d[IX_F][FLAG_N_BIT] = req_i.flag_n[0];
          if (!req_i.flag_h[1]) regs_d[IX_F][FLAG_H_BIT] = req_i.flag_h[0];
          if (!req_i.flag_c[1]) regs_d[IX_F][FLAG_C_BIT] = req_i.flag_c[0];
        end
        OP_PUSH8, OP_PUSH16: sp_d = sp_m1;
        OP_POP8, OP_POP16:   sp_d = sp_p1;
        default:             sp_d = sp_q;
      endcase
    end else if (cmd_i.step) begin
      sp_d = pend_push_q ? sp_m1 : sp_p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{default: 8'h00};
      sp_q   <= 16'h0000;
      pc_q   <= 16'h0000;
    end else begin
      regs_q <= regs_d;
      sp_q   <= sp_d;
      pc_q   <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q       <= res_first;
      pend_push_q <= (req_i.opcode == OP_PUSH16);
      pend_data_q <= (req_i.opcode == OP_PUSH16) ? req_i.wdata : req_i.stack_bytes;
    end else if (cmd_i.step) begin
      out_q <= res_second;
    end
  end

endmodule

/* sv/cpu_register_file_with_flags_and_stack_core.sv */
// A result is presented in the cycle after its input transaction is accepted. Register,
// flag and 8-bit stack operations go at one item per cycle unless the output stalls;
// 16-bit push and pop make their two byte accesses in turn through the result register.
// The single result register sets the rate: a new item enters as its final result leaves.
// Reset (rst_ni low, asynchronous): A, F, B, C, D, E, H, L, SP and PC clear to zero
// and the output goes empty.
`include "assert_macros.svh"

module cpu_register_file_with_flags_and_stack_core (
  input  logic clk_i,
  input  logic rst_ni,
  crf_req_if.sink   req_i,
  crf_rsp_if.source rsp_o
);
  import crf_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;
  rsp_t rsp_data;

  // Controller: sequences the load of a new item and, for 16-bit stack
  // operations, the second byte access once the first has been taken.
  crf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(rsp_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: register file, flags, SP/PC and the result register.
  crf_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i.data),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp_data)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;
  assign rsp_o.data  = rsp_data;

  // Never overwrite a result that is still waiting.
  `CRF_ASSERT(a_no_overwrite, clk_i, rst_ni,
              !(req_i.valid && req_i.ready && rsp_o.valid && !rsp_o.ready),
              "input accepted over a stalled result")
  // Hold off new input while the first half of a two-byte access is out.
  `CRF_ASSERT(a_first_blocks, clk_i, rst_ni,
              (rsp_o.valid && !rsp_o.data.last) |-> !req_i.ready,
              "input ready while a second byte is pending")
  // A 16-bit push or pop presents a non-final first result next cycle.
  `CRF_ASSERT(a_two_beat, clk_i, rst_ni,
              (req_i.valid && req_i.ready && (req_i.data.opcode == OP_PUSH16 ||
               req_i.data.opcode == OP_POP16)) |=> (rsp_o.valid && !rsp_o.data.last),
              "two-byte access did not start")
  // Output is empty right out of reset.
  `CRF_ASSERT_ALWAYS(a_reset_empty, clk_i,
                     $rose(rst_ni) |-> !rsp_o.valid,
                     "result valid right after reset")

endmodule

/* tb/cpu_register_file_with_flags_and_stack_core_tb.sv */
module cpu_register_file_with_flags_and_stack_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crf_pkg::*;

  // Selectors and conditions the block does not decode
  localparam logic [3:0] SEL_UNUSED_LO = 4'd14;
  localparam logic [3:0] SEL_UNUSED_HI = 4'd15;
  localparam logic [2:0] CND_UNUSED    = 3'd7;

  // Cycles without any transaction on either side before the run is abandoned
  localparam int unsigned STALL_LIMIT = 1000;
  // Cycles to let pass after the last result before the verdict
  localparam int unsigned TAIL_CYCLES = 4;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  crf_req_if req_if ();
  crf_rsp_if rsp_if ();

  cpu_register_file_with_flags_and_stack_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirror of the register file, kept in step with every accepted transaction
  logic [7:0]  byte_bank [NUM_BYTE_REGS];
  logic [15:0] sp_mirror;
  logic [15:0] pc_mirror;

  // Results owed by the block, oldest first
  rsp_t        cpu_result_q [$];
  rsp_t        owed;
  int unsigned mismatches = 0;

  // Random idling on each side; cleared for the last stretch of the run
  bit src_idle_on  = 1'b1;
  bit sink_idle_on = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Register file mirror
  // ---------------------------------------------------------------------------

  function automatic logic [15:0] bank_read(logic [3:0] sel);
    case (sel)
      SEL_A:   return {8'h00, byte_bank[IX_A]};
      SEL_F:   return {8'h00, byte_bank[IX_F]};
      SEL_B:   return {8'h00, byte_bank[IX_B]};
      SEL_C:   return {8'h00, byte_bank[IX_C]};
      SEL_D:   return {8'h00, byte_bank[IX_D]};
      SEL_E:   return {8'h00, byte_bank[IX_E]};
      SEL_H:   return {8'h00, byte_bank[IX_H]};
      SEL_L:   return {8'h00, byte_bank[IX_L]};
      SEL_AF:  return {byte_bank[IX_A], byte_bank[IX_F]};
      SEL_BC:  return {byte_bank[IX_B], byte_bank[IX_C]};
      SEL_DE:  return {byte_bank[IX_D], byte_bank[IX_E]};
      SEL_HL:  return {byte_bank[IX_H], byte_bank[IX_L]};
      SEL_SP:  return sp_mirror;
      SEL_PC:  return pc_mirror;
      default: return 16'h0000;
    endcase
  endfunction

  task automatic bank_write(logic [3:0] sel, logic [15:0] value);
    case (sel)
      SEL_A:  byte_bank[IX_A] = value[7:0];
      SEL_F:  byte_bank[IX_F] = value[7:0];
      SEL_B:  byte_bank[IX_B] = value[7:0];
      SEL_C:  byte_bank[IX_C] = value[7:0];
      SEL_D:  byte_bank[IX_D] = value[7:0];
      SEL_E:  byte_bank[IX_E] = value[7:0];
      SEL_H:  byte_bank[IX_H] = value[7:0];
      SEL_L:  byte_bank[IX_L] = value[7:0];
      SEL_AF: {byte_bank[IX_A], byte_bank[IX_F]} = value;
      SEL_BC: {byte_bank[IX_B], byte_bank[IX_C]} = value;
      SEL_DE: {byte_bank[IX_D], byte_bank[IX_E]} = value;
      SEL_HL: {byte_bank[IX_H], byte_bank[IX_L]} = value;
      SEL_SP: sp_mirror = value;
      SEL_PC: pc_mirror = value;
      default: ;
    endcase
    // Low nibble of F reads back as zero whatever was written
    byte_bank[IX_F][3:0] = 4'h0;
  endtask

  // Codes 0 and 1 set the flag; 2 and 3 hold it
  function automatic logic [7:0] update_flag(logic [7:0] f, logic [1:0] code,
                                             logic [2:0] pos);
    logic [7:0] res;
    res = f;
    if (!code[1]) res[pos] = code[0];
    return res;
  endfunction

  // Apply one operation to the mirror and queue the results it owes
  task automatic apply_cpu_op(req_t item);
    rsp_t first;
    rsp_t second;
    bit   two_beat;
    logic zf;
    logic cf;
    first    = '0;
    second   = '0;
    two_beat = 1'b0;
    zf       = byte_bank[IX_F][FLAG_Z_BIT];
    cf       = byte_bank[IX_F][FLAG_C_BIT];
    first.last  = 1'b1;
    second.last = 1'b1;
    case (item.opcode)
      OP_READ: first.rdata = bank_read(item.reg_sel);
      OP_WRITE: bank_write(item.reg_sel, item.wdata);
      OP_SETF: begin
        byte_bank[IX_F] = update_flag(byte_bank[IX_F], item.flag_z, FLAG_Z_BIT);
        byte_bank[IX_F] = update_flag(byte_bank[IX_F], item.flag_n, FLAG_N_BIT);
        byte_bank[IX_F] = update_flag(byte_bank[IX_F], item.flag_h, FLAG_H_BIT);
        byte_bank[IX_F] = update_flag(byte_bank[IX_F], item.flag_c, FLAG_C_BIT);
      end
      OP_TEST: begin
        case (item.cond)
          CND_NONE: first.cond_true = 1'b1;
          CND_Z:    first.cond_true = zf;
          CND_NZ:   first.cond_true = !zf;
          CND_C:    first.cond_true = cf;
          CND_NC:   first.cond_true = !cf;
          default:  first.cond_true = 1'b0;
        endcase
      end
      OP_PUSH8: begin
        sp_mirror        = sp_mirror - 16'd1;
        first.bus_valid  = 1'b1;
        first.bus_write  = 1'b1;
        first.bus_addr   = sp_mirror;
        first.bus_byte   = item.wdata[7:0];
      end
      OP_PUSH16: begin
        // High byte goes to the higher address
        two_beat         = 1'b1;
        sp_mirror        = sp_mirror - 16'd1;
        first.bus_valid  = 1'b1;
        first.bus_write  = 1'b1;
        first.bus_addr   = sp_mirror;
        first.bus_byte   = item.wdata[15:8];
        first.last       = 1'b0;
        sp_mirror        = sp_mirror - 16'd1;
        second.bus_valid = 1'b1;
        second.bus_write = 1'b1;
        second.bus_addr  = sp_mirror;
        second.bus_byte  = item.wdata[7:0];
      end
      OP_POP8: begin
        first.bus_valid  = 1'b1;
        first.bus_addr   = sp_mirror;
        first.rdata      = {8'h00, item.stack_bytes[7:0]};
        sp_mirror        = sp_mirror + 16'd1;
      end
      OP_POP16: begin
        // The popped word comes back only with the second access
        two_beat         = 1'b1;
        first.bus_valid  = 1'b1;
        first.bus_addr   = sp_mirror;
        first.last       = 1'b0;
        sp_mirror        = sp_mirror + 16'd1;
        second.bus_valid = 1'b1;
        second.bus_addr  = sp_mirror;
        second.rdata     = item.stack_bytes;
        sp_mirror        = sp_mirror + 16'd1;
      end
      default: ;
    endcase
    cpu_result_q.push_back(first);
    if (two_beat) cpu_result_q.push_back(second);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Present one transaction, optionally after a short gap, and hold it until
  // the block takes it. The mirror advances at the accepting edge.
  task automatic send_item(req_t item);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    apply_cpu_op(item);
  endtask

  // Register and stack operations; the value doubles as the stack bytes
  task automatic send_reg(op_e op, logic [3:0] sel, logic [15:0] value);
    req_t item;
    item             = '0;
    item.opcode      = op;
    item.reg_sel     = sel;
    item.wdata       = value;
    item.stack_bytes = value;
    send_item(item);
  endtask

  task automatic send_flags(logic [1:0] fz, logic [1:0] fn, logic [1:0] fh, logic [1:0] fc);
    req_t item;
    item        = '0;
    item.opcode = OP_SETF;
    item.flag_z = fz;
    item.flag_n = fn;
    item.flag_h = fh;
    item.flag_c = fc;
    send_item(item);
  endtask

  task automatic send_test(logic [2:0] cnd);
    req_t item;
    item        = '0;
    item.opcode = OP_TEST;
    item.cond   = cnd;
    send_item(item);
  endtask

  // Random operation: every field spans its full width, with extra weight on
  // the all-zero and all-one data words
  function automatic req_t random_item();
    req_t item;
    item.opcode      = op_e'($urandom_range(0, 7));
    item.reg_sel     = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       item.wdata = 16'h0000;
      1:       item.wdata = 16'hFFFF;
      default: item.wdata = 16'($urandom);
    endcase
    item.flag_z      = 2'($urandom_range(0, 3));
    item.flag_n      = 2'($urandom_range(0, 3));
    item.flag_h      = 2'($urandom_range(0, 3));
    item.flag_c      = 2'($urandom_range(0, 3));
    item.cond        = 3'($urandom_range(0, 7));
    item.stack_bytes = 16'($urandom);
    return item;
  endfunction

  // Stop offering work until every owed result has left the block
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (cpu_result_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // AF and PC read zero after reset, and an undecoded selector reads zero
  task automatic test_reset_state();
    send_reg(OP_READ, SEL_AF, 16'h0000);
    send_reg(OP_READ, SEL_PC, 16'h0000);
    send_reg(OP_READ, SEL_UNUSED_HI, 16'h0000);
  endtask

  // Full-scale writes, forced-zero F nibble, a write to an undecoded selector
  task automatic test_register_access();
    send_reg(OP_WRITE, SEL_AF, 16'hFFFF);
    send_reg(OP_READ, SEL_F, 16'h0000);
    send_reg(OP_WRITE, SEL_HL, 16'hA55A);
    send_reg(OP_READ, SEL_L, 16'h0000);
    send_reg(OP_WRITE, SEL_UNUSED_LO, 16'hFFFF);
    send_reg(OP_READ, SEL_UNUSED_LO, 16'h0000);
    send_reg(OP_WRITE, SEL_PC, 16'hFFFF);
    send_reg(OP_READ, SEL_PC, 16'h0000);
  endtask

  // Push below address zero and pop back across the top of memory
  task automatic test_stack_wrap();
    send_reg(OP_WRITE, SEL_SP, 16'h0000);
    send_reg(OP_PUSH8, SEL_A, 16'h00FF);
    send_reg(OP_PUSH16, SEL_A, 16'hFFFF);
    send_reg(OP_POP16, SEL_A, 16'hFFFF);
    send_reg(OP_POP8, SEL_A, 16'h00FF);
    send_reg(OP_READ, SEL_SP, 16'h0000);
  endtask

  // Clear, set and hold every flag; try each condition including an undecoded one
  task automatic test_flags_and_conditions();
    send_flags(2'd0, 2'd0, 2'd0, 2'd0);
    send_test(CND_Z);
    send_test(CND_NC);
    send_flags(2'd1, 2'd1, 2'd1, 2'd1);
    send_test(CND_C);
    send_flags(2'd2, 2'd3, 2'd2, 2'd3);
    send_test(CND_NZ);
    send_test(CND_NONE);
    send_test(CND_UNUSED);
  endtask

  // Bulk random traffic with idling on both sides
  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // Short bursts, each followed by a full drain of the result side
  task automatic test_drained_bursts(int unsigned bursts);
    repeat (bursts) begin
      repeat ($urandom_range(5, 30)) send_item(random_item());
      drain_results();
    end
  endtask

  // Back-to-back traffic with both sides always ready
  task automatic test_unthrottled_traffic(int unsigned count);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (count) send_item(random_item());
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Drop ready for bursts of random length
  initial begin : result_sink
    int unsigned stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        rsp_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted result with the oldest one owed
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (cpu_result_q.size() == 0) begin
        $error("result 0x%0h arrived with nothing owed", rsp_if.data);
        mismatches++;
      end else begin
        owed = cpu_result_q.pop_front();
        check_field("rdata", owed.rdata, rsp_if.data.rdata);
        check_field("cond_true", 16'(owed.cond_true), 16'(rsp_if.data.cond_true));
        check_field("bus_valid", 16'(owed.bus_valid), 16'(rsp_if.data.bus_valid));
        check_field("bus_write", 16'(owed.bus_write), 16'(rsp_if.data.bus_write));
        check_field("bus_addr", owed.bus_addr, rsp_if.data.bus_addr);
        check_field("bus_byte", 16'(owed.bus_byte), 16'(rsp_if.data.bus_byte));
        check_field("last", 16'(owed.last), 16'(rsp_if.data.last));
      end
    end
  end

  // Abandon the run when neither side has moved a transaction for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    byte_bank = '{default: 8'h00};
    sp_mirror = 16'h0000;
    pc_mirror = 16'h0000;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;

    // Hold reset, then release it on an edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_access();
    test_stack_wrap();
    test_flags_and_conditions();
    test_random_traffic(1000);
    test_drained_bursts(6);
    test_unthrottled_traffic(200);

    // Let the last results out, then let TAIL_CYCLES pass quietly before the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && cpu_result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* cpu_register_file_with_flags_and_stack_core.f */
+incdir+sv
sv/crf_pkg.sv
sv/crf_if.sv
sv/crf_ctrl.sv
sv/crf_dp.sv
sv/cpu_register_file_with_flags_and_stack_core.sv
tb/cpu_register_file_with_flags_and_stack_core_tb.sv
